// ----- sv/bfspe_pkg.sv -----
// Shared constants, types and command codes of the subspace point evaluator.
`timescale 1ns / 1ps
`default_nettype none
package bfspe_pkg;

  localparam int WORD_W             = 64;
  localparam int TABLE_DEPTH        = 64;
  localparam int ADDR_W             = 6;
  localparam int FB_W               = 7;
  localparam int CFG_IDX_W          = 1;
  localparam int MAX_FIELD_BITS_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_POLY = 1'd1;

  localparam logic [FB_W-1:0]   FIELD_BITS_RST = 7'd64;
  localparam logic [WORD_W-1:0] POLY_RST       = 64'd27;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_COMBINE = 3'd2,
    CMD_SETUP   = 3'd3,
    CMD_ROUND   = 3'd4
  } alu_cmd_t;

  typedef struct packed {
    alu_cmd_t cmd;
    logic     sel;
  } alu_ctrl_t;

  typedef struct packed {
    logic point_one;
  } alu_stat_t;

endpackage
`default_nettype wire

// ----- sv/bfspe_basis_mem.sv -----
// Basis element table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bfspe_basis_mem
  import bfspe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/bfspe_alu.sv -----
// Shared XOR accumulate and shift-reduce unit for basis combination and multiply.
`timescale 1ns / 1ps
`default_nettype none
module bfspe_alu
  import bfspe_pkg::*;
(
  input  wire logic              clk,
  input  wire alu_ctrl_t         ctrl,
  input  wire logic [WORD_W-1:0] rdata,
  input  wire logic [WORD_W-1:0] c0,
  input  wire logic [WORD_W-1:0] c1,
  input  wire logic [WORD_W-1:0] mask,
  input  wire logic [WORD_W-1:0] poly,
  input  wire logic [ADDR_W-1:0] msb,
  output logic      [WORD_W-1:0] acc,
  output alu_stat_t              stat
);

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] c0_m;
  logic [WORD_W-1:0] c1_m;
  logic [WORD_W-1:0] point;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] a_shift;

  assign c0_m      = c0 & mask;
  assign c1_m      = c1 & mask;
  assign point     = acc & mask;
  assign a_shift   = ((a << 1) & mask) ^ (a[msb] ? (poly & mask) : '0);
  assign operand   = (ctrl.cmd == CMD_ROUND) ? (b[0] ? a : '0)
                                              : (ctrl.sel ? rdata : '0);
  assign stat.point_one = (point == WORD_W'(1));

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      CMD_HOLD: begin
      end
      CMD_CLEAR: begin
        acc <= '0;
      end
      CMD_COMBINE: begin
        acc <= acc ^ operand;
      end
      CMD_SETUP: begin
        b   <= point;
        a   <= c1_m;
        acc <= stat.point_one ? (c0_m ^ c1_m) : c0_m;
      end
      CMD_ROUND: begin
        acc <= acc ^ operand;
        a   <= a_shift;
        b   <= b >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/binary_field_subspace_point_eval_core.sv -----
// Top level: sequencer, configuration registers and output register.
// Load word: written to the table on acceptance, input stays ready, no result.
// Evaluate word: COMBINE, LAST, PREP, MULT (skipped when the point is one), then
// FINISH registers the result once the output is free; the next word waits for that.
// The shared XOR/shift unit first combines the basis words, then multiplies.
// Synchronous reset sets field degree 64 and polynomial 27; table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binary_field_subspace_point_eval_core
  import bfspe_pkg::*;
#(
  parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 operation,
  input  wire logic [ADDR_W-1:0]    basis_slot,
  input  wire logic [WORD_W-1:0]    basis_word,
  input  wire logic [WORD_W-1:0]    point_index,
  input  wire logic [WORD_W-1:0]    constant_coeff,
  input  wire logic [WORD_W-1:0]    linear_coeff,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [WORD_W-1:0]    value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  localparam logic [ADDR_W-1:0] TOP_BIT = ADDR_W'(WORD_W - 1);
  localparam logic [FB_W-1:0]   MAX_FB  = FB_W'(MAX_FIELD_BITS);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_COMBINE = 6'b000010,
    ST_LAST    = 6'b000100,
    ST_PREP    = 6'b001000,
    ST_MULT    = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_t;

  state_t            state;
  logic [FB_W-1:0]   field_bits;
  logic [WORD_W-1:0] reduction_poly;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] msb;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] index;
  logic [WORD_W-1:0] c0;
  logic [WORD_W-1:0] c1;
  logic              rd_bit;

  logic [FB_W-1:0]   m_eff;
  logic [ADDR_W-1:0] msb_next;
  logic              accept;
  logic              accept_load;
  logic              accept_eval;
  logic              out_free;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] acc;
  alu_ctrl_t         ctrl;
  alu_stat_t         stat;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign accept_load = accept && (operation == OP_LOAD);
  assign accept_eval = accept && (operation == OP_EVAL);
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    priority if (field_bits == '0) begin
      m_eff = FB_W'(1);
    end else if (field_bits > MAX_FB) begin
      m_eff = MAX_FB;
    end else begin
      m_eff = field_bits;
    end
  end
  assign msb_next = ADDR_W'(m_eff - FB_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      field_bits     <= FIELD_BITS_RST;
      reduction_poly <= POLY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIELD_BITS:     field_bits     <= cfg_data[FB_W-1:0];
        CFG_REDUCTION_POLY: reduction_poly <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    ctrl.cmd = CMD_HOLD;
    ctrl.sel = rd_bit;
    unique case (state)
      ST_IDLE:    ctrl.cmd = accept_eval ? CMD_CLEAR : CMD_HOLD;
      ST_COMBINE: ctrl.cmd = (cnt != '0) ? CMD_COMBINE : CMD_HOLD;
      ST_LAST:    ctrl.cmd = CMD_COMBINE;
      ST_PREP:    ctrl.cmd = CMD_SETUP;
      ST_MULT:    ctrl.cmd = CMD_ROUND;
      ST_FINISH:  ctrl.cmd = CMD_HOLD;
      default:    ctrl.cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_eval) begin
            cnt   <= '0;
            state <= ST_COMBINE;
          end
        end
        ST_COMBINE: begin
          if (cnt == msb) begin
            state <= ST_LAST;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_LAST: begin
          state <= ST_PREP;
        end
        ST_PREP: begin
          cnt   <= '0;
          state <= stat.point_one ? ST_FINISH : ST_MULT;
        end
        ST_MULT: begin
          if (cnt == msb) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_eval) begin
      msb   <= msb_next;
      mask  <= {WORD_W{1'b1}} >> (TOP_BIT - msb_next);
      index <= point_index;
      c0    <= constant_coeff;
      c1    <= linear_coeff;
    end
    if (state == ST_COMBINE) begin
      rd_bit <= index[cnt];
    end
    if (state == ST_FINISH && out_free) begin
      value <= acc;
    end
  end

  bfspe_basis_mem u_mem (
    .clk   (clk),
    .we    (accept_load),
    .waddr (basis_slot),
    .wdata (basis_word),
    .raddr (cnt),
    .rdata (rdata)
  );

  bfspe_alu u_alu (
    .clk   (clk),
    .ctrl  (ctrl),
    .rdata (rdata),
    .c0    (c0),
    .c1    (c1),
    .mask  (mask),
    .poly  (reduction_poly),
    .msb   (msb),
    .acc   (acc),
    .stat  (stat)
  );

endmodule
`default_nettype wire

// ----- sv/bfspe_checker.sv -----
// Port-level checks of the evaluator and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfspe_checker
  import bfspe_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              operation,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result word dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_EVAL) |=> !in_ready)
    else $error("evaluate word did not occupy the unit");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_LOAD) |=> in_ready)
    else $error("load word stalled the input");

endmodule

bind binary_field_subspace_point_eval_core bfspe_checker u_bfspe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .operation (operation),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value)
);
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the subspace point evaluator core.
`timescale 1ns / 1ps
module tb_top;
  import bfspe_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = OP_LOAD;
  logic [ADDR_W-1:0] basis_slot = '0;
  logic [WORD_W-1:0] basis_word = '0;
  logic [WORD_W-1:0] point_index = '0;
  logic [WORD_W-1:0] constant_coeff = '0;
  logic [WORD_W-1:0] linear_coeff = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FIELD_BITS;
  logic [WORD_W-1:0] cfg_data = '0;

  logic [FB_W-1:0] field_cfg = FIELD_BITS_RST;
  logic [WORD_W-1:0] poly_cfg = POLY_RST;
  logic [WORD_W-1:0] basis_copy [TABLE_DEPTH];
  logic [WORD_W-1:0] expected_values [$];
  int fail_count = 0;
  bit steady = 1'b0;

  binary_field_subspace_point_eval_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .basis_slot(basis_slot),
    .basis_word(basis_word),
    .point_index(point_index),
    .constant_coeff(constant_coeff),
    .linear_coeff(linear_coeff),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int field_degree();
    if (field_cfg == 0) return 1;
    if (field_cfg > 64) return 64;
    return field_cfg;
  endfunction

  function automatic logic [WORD_W-1:0] subspace_value(logic [WORD_W-1:0] idx,
                                                       logic [WORD_W-1:0] c0,
                                                       logic [WORD_W-1:0] c1);
    int m;
    logic [WORD_W-1:0] mask, poly, pt, a, b, acc, top;
    logic carry;
    m = field_degree();
    mask = (m == 64) ? '1 : (64'd1 << m) - 64'd1;
    poly = poly_cfg & mask;
    pt = '0;
    for (int j = 0; j < m; j++) begin
      if (idx[j]) pt ^= basis_copy[j];
    end
    pt &= mask;
    if (pt == 64'd1) return (c0 ^ c1) & mask;
    a = c1 & mask;
    b = pt;
    acc = '0;
    top = 64'd1 << (m - 1);
    for (int r = 0; r < m; r++) begin
      if (b[0]) acc ^= a;
      b >>= 1;
      carry = |(a & top);
      a = ((a & ~top) << 1) & mask;
      if (carry) a ^= poly;
    end
    return (c0 & mask) ^ (acc & mask);
  endfunction

  task automatic report_error(input string what, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    if (fail_count < 10) $display("%s: expected %h got %h", what, want, got);
    fail_count++;
  endtask

  task automatic send_word(input logic op, input logic [ADDR_W-1:0] slot,
                           input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] idx,
                           input logic [WORD_W-1:0] c0, input logic [WORD_W-1:0] c1);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    basis_slot <= slot;
    basis_word <= word;
    point_index <= idx;
    constant_coeff <= c0;
    linear_coeff <= c1;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD) basis_copy[slot] = word;
    else expected_values.push_back(subspace_value(idx, c0, c1));
  endtask

  task automatic load_basis(input logic [ADDR_W-1:0] slot, input logic [WORD_W-1:0] word);
    send_word(OP_LOAD, slot, word, rand_word(), rand_word(), rand_word());
  endtask

  task automatic evaluate(input logic [WORD_W-1:0] idx, input logic [WORD_W-1:0] c0,
                          input logic [WORD_W-1:0] c1);
    send_word(OP_EVAL, ADDR_W'($urandom), rand_word(), idx, c0, c1);
  endtask

  // drop valid, wait out pending results and any load still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (2 * MAX_FIELD_BITS_DEF + 8) @(posedge clk);
  endtask

  task automatic configure(input logic [FB_W-1:0] fb, input logic [WORD_W-1:0] poly);
    logic [WORD_W-1:0] word;
    word = rand_word();
    word[FB_W-1:0] = fb;
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIELD_BITS;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    field_cfg = fb;
    cfg_index <= CFG_REDUCTION_POLY;
    cfg_data <= poly;
    do @(posedge clk); while (!cfg_ready);
    poly_cfg = poly;
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_pacing
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(!rst && out_valid === 1'b1 && out_ready));
    end
  end

  always @(posedge clk) begin : result_check
    logic [WORD_W-1:0] want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_values.size() == 0) begin
        report_error("result with no pending evaluation", '0, value);
      end else begin
        want = expected_values.pop_front();
        if (value !== want) report_error("value mismatch", want, value);
      end
    end
  end

  task automatic test_default_field();
    load_basis(6'd0, 64'd1);
    load_basis(6'd63, '1);
    load_basis(6'd1, 64'h8000_0000_0000_0000);
    evaluate(64'd1, 64'h1234_5678_9ABC_DEF0, '1);
    evaluate(64'd0, '1, rand_word());
    evaluate(64'd2, 64'd0, '1);
    evaluate(64'h8000_0000_0000_0003, rand_word(), rand_word());
    evaluate(64'd2, 64'd0, 64'd0);
    evaluate(64'h8000_0000_0000_0002, '1, 64'h8000_0000_0000_0001);
  endtask

  task automatic test_degenerate_degree();
    settle();
    configure(7'd1, '1);
    evaluate('1, '1, '1);
    evaluate(64'hFFFF_FFFF_FFFF_FFFE, 64'd0, '1);
    evaluate(64'd1, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1);
    settle();
    configure(7'd0, 64'd0);
    evaluate('1, '1, '1);
  endtask

  task automatic test_clamped_and_narrow_degree();
    settle();
    configure(7'd127, 64'h1B);
    evaluate(64'h8000_0000_0000_0002, rand_word(), '1);
    settle();
    configure(7'd8, 64'hFFFF_FFFF_FFFF_FF1B);
    load_basis(6'd2, 64'hFFFF_FFFF_FFFF_FF53);
    evaluate(64'hFFFF_FFFF_FFFF_FF04, 64'd0, 64'hABCD_0000_0000_00CA);
    evaluate(64'hFFFF_FFFF_FFFF_FF07, '1, '1);
  endtask

  task automatic test_random_traffic();
    logic [FB_W-1:0] edge_degrees [6];
    logic [FB_W-1:0] fb;
    logic [WORD_W-1:0] poly, word, idx, c1;
    edge_degrees = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd63};
    for (int s = 0; s < TABLE_DEPTH; s++) load_basis(ADDR_W'(s), rand_word());
    for (int p = 0; p < 12; p++) begin
      settle();
      steady = (p % 4 == 3);
      if (p < 6) fb = edge_degrees[p];
      else if ($urandom_range(0, 1) == 0) fb = FB_W'($urandom_range(1, 16));
      else fb = FB_W'($urandom_range(0, 127));
      case ($urandom_range(0, 5))
        0: poly = '0;
        1: poly = '1;
        2: poly = POLY_RST;
        default: poly = rand_word();
      endcase
      configure(fb, poly);
      for (int k = 0; k < 125; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 7))
            0: word = 64'd1;
            1: word = 64'd1 << $urandom_range(0, 63);
            default: word = rand_word();
          endcase
          load_basis(ADDR_W'($urandom), word);
        end else begin
          if ($urandom_range(0, 3) == 0) idx = 64'd1 << $urandom_range(0, field_degree() - 1);
          else idx = rand_word();
          case ($urandom_range(0, 7))
            0: c1 = '0;
            1: c1 = '1;
            default: c1 = rand_word();
          endcase
          evaluate(idx, rand_word(), c1);
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_default_field();
    test_degenerate_degree();
    test_clamped_and_narrow_degree();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("[binary_field_subspace_point_eval_core] OK");
    end else begin
      $display("[binary_field_subspace_point_eval_core] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[binary_field_subspace_point_eval_core] ERROR");
    $finish;
  end

endmodule
